// ===== rtl/core/meo_pkg.sv =====
// ----------------------------------------------------------------------------
// meo_pkg
// Shared types and constants for the mecanum odometry block.
// ----------------------------------------------------------------------------
package meo_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 8'd1;

    localparam logic [31:0] LINEAR_GAIN_RST  = 32'd605975;
    localparam logic [31:0] ANGULAR_GAIN_RST = 32'd287122;

    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] enc_count_0;
        logic signed [31:0] enc_count_1;
        logic signed [31:0] enc_count_2;
        logic signed [31:0] enc_count_3;
    } meo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading_angle;
    } meo_out_t;

    // arctan(2^-i) as a binary angle
    function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mecanum_encoder_odometry.sv =====
// ----------------------------------------------------------------------------
// mecanum_encoder_odometry
// Four-wheel mecanum odometry: encoder counts in, saturating pose out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries four absolute encoder counts (low ENC_WIDTH bits
//           used). Each beat updates the pose and yields one out beat.
//   out_* : pos_x / pos_y (Q16.16 m, saturating) and heading_angle (binary
//           angle, wraps).
//   cfg_* : write-only registers, index 0 linear_gain, 1 angular_gain; other
//           indexes are dropped. Write only while the block is idle.
// Sequence:
//   Each accepted beat runs heading and linear scaling on the shared 35x34
//   multiplier, then the 30-step CORDIC, then the rotation steps, the last of
//   which also loads the output register.
//   in_ready is high only while the sequencer is idle and returns on the edge
//   that loads the output register, so a new beat is taken only after that load.
// Reset:
//   Counts, pose and heading clear to zero; gains return to their defaults.
// Stall:
//   The result sits in an output register; a new beat may be accepted while
//   it waits. If the next result is ready before the old one is taken, the
//   sequencer holds in its last step until out_ready.
// ----------------------------------------------------------------------------
module mecanum_encoder_odometry
#(
    parameter int ENC_WIDTH = 32
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  meo_pkg::meo_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output meo_pkg::meo_out_t                  out_data,
    input  logic                               cfg_we,
    input  logic [meo_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [31:0]                        cfg_wdata
);
    import meo_pkg::*;

    localparam int SUM_W  = 34;   // |sum of four deltas| <= 2^33
    localparam int MA_W   = 35;
    localparam int MB_W   = 34;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 66;
    localparam int SC_W   = 52;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_CORD, ST_ROT} state_t;

    state_t                      state_reg;
    logic [2:0]                  ph_reg;
    logic [31:0]                 lin_gain_reg;
    logic [31:0]                 ang_gain_reg;
    logic [ENC_WIDTH-1:0]        last_reg [4];
    logic signed [SUM_W-1:0]     sr_reg;
    logic [SUM_W-1:0]            ml_reg;
    logic [SUM_W-1:0]            mt_reg;
    logic                        nl_reg;
    logic                        nt_reg;
    logic [31:0]                 heading_reg;
    logic signed [31:0]          x_reg;
    logic signed [31:0]          y_reg;
    logic signed [31:0]          dl_reg;
    logic signed [31:0]          dt_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    hi_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        out_valid_reg;
    meo_out_t                    out_reg;

    logic signed [SUM_W-1:0]     d [4];
    logic signed [SUM_W-1:0]     sl_c;
    logic signed [SUM_W-1:0]     st_c;
    logic signed [SUM_W-1:0]     sr_c;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [31:0]          scaled;
    logic                        scale_neg;
    logic [SC_W-1:0]             sc_r;
    logic signed [36:0]          pos_sum;
    logic signed [31:0]          pos_sat;
    logic signed [31:0]          pos_old;
    logic                        cord_start;
    logic                        cord_done;
    logic signed [CORDIC_W-1:0]  cos_v;
    logic signed [CORDIC_W-1:0]  sin_v;
    logic                        in_fire;
    logic                        out_free;
    logic                        out_load;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == ST_ROT) && (ph_reg == 3'd5) && out_free;

    // wrapped deltas against the previous sample
    always_comb
    begin
        logic [ENC_WIDTH-1:0] cur [4];
        logic [ENC_WIDTH-1:0] dw;
        cur[0] = in_data.enc_count_0[ENC_WIDTH-1:0];
        cur[1] = in_data.enc_count_1[ENC_WIDTH-1:0];
        cur[2] = in_data.enc_count_2[ENC_WIDTH-1:0];
        cur[3] = in_data.enc_count_3[ENC_WIDTH-1:0];
        for (int i = 0; i < 4; i++)
        begin
            dw   = cur[i] - last_reg[i];
            d[i] = {{(SUM_W-ENC_WIDTH){dw[ENC_WIDTH-1]}}, dw};
        end
        sl_c = d[0] + d[1] + d[2] + d[3];
        st_c = d[0] - d[1] - d[2] + d[3];
        sr_c = d[0] - d[1] + d[2] - d[3];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_MUL)
        begin
            case (ph_reg)
                3'd0:
                begin
                    mul_a = {3'b000, sr_reg[31:0]};
                    mul_b = {2'b00, ang_gain_reg};
                end
                3'd1:
                begin
                    mul_a = {1'b0, ml_reg};
                    mul_b = {18'd0, lin_gain_reg[31:16]};
                end
                3'd2:
                begin
                    mul_a = {1'b0, ml_reg};
                    mul_b = {18'd0, lin_gain_reg[15:0]};
                end
                3'd3:
                begin
                    mul_a = {1'b0, mt_reg};
                    mul_b = {18'd0, lin_gain_reg[31:16]};
                end
                3'd4:
                begin
                    mul_a = {1'b0, mt_reg};
                    mul_b = {18'd0, lin_gain_reg[15:0]};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_ROT)
        begin
            case (ph_reg)
                3'd0:
                begin
                    mul_a = MA_W'(dl_reg);
                    mul_b = cos_v;
                end
                3'd1:
                begin
                    mul_a = MA_W'(dt_reg);
                    mul_b = sin_v;
                end
                3'd2:
                begin
                    mul_a = MA_W'(dl_reg);
                    mul_b = sin_v;
                end
                3'd3:
                begin
                    mul_a = MA_W'(dt_reg);
                    mul_b = cos_v;
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // linear scaling: hi part plus rounded lo part, then sign and clamp
    assign scale_neg = (ph_reg == 3'd3) ? nl_reg : nt_reg;
    always_comb
    begin
        logic [SC_W-1:0] lo_part;
        lo_part = (SC_W'(prod_reg[49:0]) + SC_W'(32'h8000)) >> 16;
        sc_r    = SC_W'(hi_reg[49:0]) + lo_part;
        if (!scale_neg)
        begin
            scaled = (sc_r > SC_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(sc_r[31:0]);
        end
        else
        begin
            scaled = (sc_r >= SC_W'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000
                                                           : -$signed(sc_r[31:0]);
        end
    end

    // rotation accumulate and saturating position update
    assign acc_sum = acc_reg + ACC_W'(prod_reg);
    assign pos_old = (ph_reg == 3'd3) ? x_reg : y_reg;
    always_comb
    begin
        logic signed [ACC_W-1:0] accv;
        logic signed [35:0]      dpos;
        accv    = (ph_reg == 3'd3) ? acc_reg : acc_sum;
        dpos    = 36'(accv >>> 30);
        pos_sum = 37'(pos_old) + 37'(dpos);
        if (pos_sum > 37'sh0_7FFF_FFFF)
            pos_sat = 32'sh7FFF_FFFF;
        else if (pos_sum < -37'sh0_8000_0000)
            pos_sat = 32'sh8000_0000;
        else
            pos_sat = pos_sum[31:0];
    end

    assign cord_start = (state_reg == ST_MUL) && (ph_reg == 3'd5);

    meo_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (heading_reg),
        .done    (cord_done),
        .cos_val (cos_v),
        .sin_val (sin_v)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg <= LINEAR_GAIN_RST;
            ang_gain_reg <= ANGULAR_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LINEAR_GAIN:  lin_gain_reg <= cfg_wdata;
                REG_ANGULAR_GAIN: ang_gain_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // sequencer and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= '0;
            heading_reg   <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else
        begin
            // a load in the same cycle keeps valid high
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        last_reg[0] <= in_data.enc_count_0[ENC_WIDTH-1:0];
                        last_reg[1] <= in_data.enc_count_1[ENC_WIDTH-1:0];
                        last_reg[2] <= in_data.enc_count_2[ENC_WIDTH-1:0];
                        last_reg[3] <= in_data.enc_count_3[ENC_WIDTH-1:0];
                        state_reg   <= ST_MUL;
                        ph_reg      <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (ph_reg == 3'd1)
                        heading_reg <= heading_reg + prod_reg[31:0];
                    if (ph_reg == 3'd5)
                    begin
                        state_reg <= ST_CORD;
                        ph_reg    <= '0;
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                ST_CORD:
                begin
                    if (cord_done)
                    begin
                        state_reg <= ST_ROT;
                        ph_reg    <= '0;
                    end
                end
                ST_ROT:
                begin
                    if (ph_reg == 3'd3)
                        x_reg <= pos_sat;
                    if (ph_reg == 3'd5)
                    begin
                        if (out_free)
                        begin
                            y_reg                 <= pos_sat;
                            out_reg.pos_x         <= x_reg;
                            out_reg.pos_y         <= pos_sat;
                            out_reg.heading_angle <= heading_reg;
                            out_valid_reg         <= 1'b1;
                            state_reg             <= ST_IDLE;
                            ph_reg                <= '0;
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ph_reg    <= '0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (in_fire)
        begin
            sr_reg <= sr_c;
            nl_reg <= sl_c[SUM_W-1];
            nt_reg <= st_c[SUM_W-1];
            ml_reg <= sl_c[SUM_W-1] ? SUM_W'(-sl_c) : SUM_W'(sl_c);
            mt_reg <= st_c[SUM_W-1] ? SUM_W'(-st_c) : SUM_W'(st_c);
        end
        if (state_reg == ST_MUL)
        begin
            case (ph_reg)
                3'd2:    hi_reg <= prod_reg;
                3'd3:    dl_reg <= scaled;
                3'd4:    hi_reg <= prod_reg;
                3'd5:    dt_reg <= scaled;
                default: ;
            endcase
        end
        if (state_reg == ST_ROT)
        begin
            case (ph_reg)
                3'd1:    acc_reg <= ACC_W'(prod_reg) + ACC_W'(64'sd536870912);
                3'd2:    acc_reg <= acc_reg - ACC_W'(prod_reg);
                3'd3:    acc_reg <= ACC_W'(prod_reg) + ACC_W'(64'sd536870912);
                3'd4:    acc_reg <= acc_sum;
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/core/meo_cordic.sv =====
// ----------------------------------------------------------------------------
// meo_cordic
// Iterative rotation-mode CORDIC: cos and sin of a binary angle, signed Q4.30 (34 bits).
// ----------------------------------------------------------------------------
module meo_cordic
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [31:0]                          angle,
    output logic                                 done,
    output logic signed [meo_pkg::CORDIC_W-1:0]  cos_val,
    output logic signed [meo_pkg::CORDIC_W-1:0]  sin_val
);
    import meo_pkg::*;

    logic                        busy_reg;
    logic                        done_reg;
    logic                        flip_reg;
    logic [4:0]                  iter_reg;
    logic signed [CORDIC_W-1:0]  x_reg;
    logic signed [CORDIC_W-1:0]  y_reg;
    logic signed [CORDIC_W-1:0]  z_reg;
    logic signed [CORDIC_W-1:0]  xs;
    logic signed [CORDIC_W-1:0]  ys;
    logic signed [CORDIC_W-1:0]  at;
    logic                        flip_in;
    logic [31:0]                 ang_adj;

    // quadrants 1 and 2 are folded by half a turn, result negated at the end
    assign flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    assign ang_adj = flip_in ? {~angle[31], angle[30:0]} : angle;

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = atan_lut(iter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (iter_reg == 5'(CORDIC_ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_K_Q30;
            y_reg    <= '0;
            z_reg    <= {{(CORDIC_W-32){ang_adj[31]}}, ang_adj};
            flip_reg <= flip_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule
